// ===== src/laplacian_edge_filter_core_macros.svh =====
// Assertion macros shared by the laplacian edge filter core.
`ifndef LAPLACIAN_EDGE_FILTER_CORE_MACROS_SVH
`define LAPLACIAN_EDGE_FILTER_CORE_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LEF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LEF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/lef_pkg.sv =====
// Types and constants shared by the laplacian edge filter modules.
`default_nettype none

package lef_pkg;

   localparam int CFG_WIDTH       = 11;
   localparam int REG_INDEX_WIDTH = 1;
   localparam int CMD_WIDTH       = 1;
   localparam int CHAN_WIDTH      = 8;
   localparam int PIX_WIDTH       = 4 * CHAN_WIDTH;
   localparam int ALPHA_LSB       = 3 * CHAN_WIDTH;
   localparam int RGB_SUM_WIDTH   = 10;
   localparam int COLSUM_WIDTH    = 10;
   localparam int SUM9_WIDTH      = 12;
   localparam int LAP_WIDTH       = SUM9_WIDTH + 1;
   localparam int SCALED_WIDTH    = LAP_WIDTH + 2;
   localparam int DIV3_SHIFT      = 11;
   localparam int DIV3_PROD_WIDTH = RGB_SUM_WIDTH + DIV3_SHIFT;

   localparam logic [DIV3_SHIFT-1:0] DIV3_MUL   = 11'd683;
   localparam logic [CHAN_WIDTH-1:0] EDGE_MAX   = 8'd255;
   localparam logic [CFG_WIDTH-1:0]  WIDTH_RST  = 11'd640;
   localparam logic [CFG_WIDTH-1:0]  HEIGHT_RST = 11'd480;

   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_WIDTH   = 2;
   localparam int QLEVEL_WIDTH = 3;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_PIXEL = 1'b0,
      CMD_DRAIN = 1'b1
   } lef_cmd_type;

   typedef enum logic [REG_INDEX_WIDTH-1:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } lef_reg_type;

   typedef struct packed {
      logic                    pixel;
      logic                    has_result;
      logic                    interior;
      logic                    frame_end;
      logic [COLSUM_WIDTH-1:0] colsum;
      logic [CHAN_WIDTH-1:0]   newer;
      logic [PIX_WIDTH-1:0]    word;
   } lef_job_type;

endpackage

`default_nettype wire

// ===== src/lef_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module lef_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== src/lef_front.sv =====
// Front end: accepts requests, keeps frame counters, line stores and pixel delay.
`default_nettype none

module lef_front import lef_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [PIX_WIDTH-1:0]       req_tdata,
   input  logic [CMD_WIDTH-1:0]       req_tuser,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [REG_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_data,
   input  logic [QLEVEL_WIDTH-1:0]    q_level,
   output logic                       q_push,
   output lef_job_type                q_job
);

   localparam int CA = $clog2(MAX_WIDTH);
   localparam int DD = MAX_WIDTH + 1;
   localparam int DA = $clog2(DD);
   localparam int PW = $clog2(MAX_WIDTH + 2);
   localparam int OW = $clog2(MAX_WIDTH * MAX_HEIGHT);
   localparam int KW = ((OW > CFG_WIDTH) ? OW : CFG_WIDTH) + 2;
   localparam int BW = $clog2(OW + 1);

   function automatic logic [CFG_WIDTH-1:0] eff_dim(input logic [CFG_WIDTH-1:0] v,
                                                    input logic [KW-1:0] lim);
      if (v == '0) begin
         return CFG_WIDTH'(1);
      end else if (KW'(v) > lim) begin
         return lim[CFG_WIDTH-1:0];
      end else begin
         return v;
      end
   endfunction

   logic [CFG_WIDTH-1:0] width_ff, width_in, height_ff, height_in;
   logic [OW-1:0]        total_m1_ff, total_m1_in;
   logic [BW-1:0]        busy_cnt_ff, busy_cnt_in;
   logic [CA-1:0]        col_in_ff, col_in_in;
   logic [PW-1:0]        pend_ff, pend_in;
   logic [DA-1:0]        head_ff, head_in, tail_ff, tail_in;
   logic [OW-1:0]        out_idx_ff, out_idx_in, out_row_ff, out_row_in;
   logic [CFG_WIDTH-1:0] out_col_ff, out_col_in;
   logic                 s1_valid_ff;
   logic                 s1_pixel_ff, s1_pop_ff, s1_interior_ff, s1_last_ff, s1_fwd_ff;
   logic [CHAN_WIDTH-1:0] s1_gray_ff, newer_hold_ff;
   logic [CA-1:0]        s1_col_ff;

   logic                       busy, accept, is_drain, pop, interior, frame_last;
   logic                       pend_full, col_wrap, out_col_wrap, div_ge;
   logic [QLEVEL_WIDTH:0]      fill;
   logic [RGB_SUM_WIDTH-1:0]   rgb_sum;
   logic [DIV3_PROD_WIDTH-1:0] rgb_prod;
   logic [CHAN_WIDTH-1:0]      gray, line_old_q, line_new_q, older_sel;
   logic [PIX_WIDTH-1:0]       delay_q;
   logic [2*CFG_WIDTH-1:0]     area;
   logic [CFG_WIDTH:0]         div_trial;
   logic [DA-1:0]              head_inc, tail_inc;

   assign csr_ready  = 1'b1;
   assign busy       = busy_cnt_ff != '0;
   assign fill       = (QLEVEL_WIDTH + 1)'(q_level) + (QLEVEL_WIDTH + 1)'(s1_valid_ff);
   assign req_tready = !busy && !csr_valid && (fill < (QLEVEL_WIDTH + 1)'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign is_drain   = req_tuser == CMD_DRAIN;

   assign pend_full  = KW'(pend_ff) > KW'(width_ff);
   assign pop        = is_drain ? (pend_ff != '0) : pend_full;
   assign interior   = (out_row_ff != '0) && (KW'(out_row_ff) + KW'(2) <= KW'(height_ff)) &&
                       (out_col_ff != '0) && (KW'(out_col_ff) + KW'(2) <= KW'(width_ff));
   assign frame_last = out_idx_ff >= total_m1_ff;

   // Gray is the channel sum divided by three through a reciprocal multiply.
   assign rgb_sum  = RGB_SUM_WIDTH'(req_tdata[CHAN_WIDTH-1:0]) +
                     RGB_SUM_WIDTH'(req_tdata[2*CHAN_WIDTH-1:CHAN_WIDTH]) +
                     RGB_SUM_WIDTH'(req_tdata[3*CHAN_WIDTH-1:2*CHAN_WIDTH]);
   assign rgb_prod = DIV3_PROD_WIDTH'(rgb_sum) * DIV3_PROD_WIDTH'(DIV3_MUL);
   assign gray     = rgb_prod[DIV3_SHIFT +: CHAN_WIDTH];

   assign col_wrap     = KW'(col_in_ff) + KW'(1) >= KW'(width_ff);
   assign out_col_wrap = KW'(out_col_ff) + KW'(1) >= KW'(width_ff);
   assign head_inc     = (head_ff == DA'(DD - 1)) ? '0 : head_ff + 1'b1;
   assign tail_inc     = (tail_ff == DA'(DD - 1)) ? '0 : tail_ff + 1'b1;
   assign area         = width_ff * height_ff;

   // One restoring division step: out_row holds dividend and quotient, out_col the remainder.
   assign div_trial = {out_col_ff, out_row_ff[OW-1]};
   assign div_ge    = div_trial >= {1'b0, width_ff};

   always_comb begin
      width_in    = width_ff;
      height_in   = height_ff;
      total_m1_in = OW'(area - 1'b1);
      busy_cnt_in = busy_cnt_ff;
      col_in_in   = col_in_ff;
      pend_in     = pend_ff;
      head_in     = head_ff;
      tail_in     = tail_ff;
      out_idx_in  = out_idx_ff;
      out_row_in  = out_row_ff;
      out_col_in  = out_col_ff;

      if (csr_valid) begin
         case (csr_index)
            REG_FRAME_WIDTH: begin
               width_in = eff_dim(csr_data, KW'(MAX_WIDTH));
            end
            REG_FRAME_HEIGHT: begin
               height_in = eff_dim(csr_data, KW'(MAX_HEIGHT));
            end
            default: begin
            end
         endcase
         busy_cnt_in = BW'(OW);
         out_col_in  = '0;
         out_row_in  = out_idx_ff;
      end else if (busy) begin
         busy_cnt_in = busy_cnt_ff - 1'b1;
         out_row_in  = {out_row_ff[OW-2:0], div_ge};
         out_col_in  = div_ge ? CFG_WIDTH'(div_trial - {1'b0, width_ff})
                              : div_trial[CFG_WIDTH-1:0];
      end else if (accept && pop) begin
         if (frame_last) begin
            out_idx_in = '0;
            out_row_in = '0;
            out_col_in = '0;
         end else begin
            out_idx_in = out_idx_ff + 1'b1;
            if (out_col_wrap) begin
               out_col_in = '0;
               out_row_in = out_row_ff + 1'b1;
            end else begin
               out_col_in = out_col_ff + 1'b1;
            end
         end
      end

      if (accept) begin
         if (!is_drain) begin
            col_in_in = col_wrap ? '0 : col_in_ff + 1'b1;
            tail_in   = tail_inc;
         end
         if (pop) begin
            head_in = head_inc;
         end
         pend_in = pend_ff - PW'(pop) + PW'(!is_drain);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= eff_dim(WIDTH_RST, KW'(MAX_WIDTH));
         height_ff   <= eff_dim(HEIGHT_RST, KW'(MAX_HEIGHT));
         total_m1_ff <= '0;
         busy_cnt_ff <= BW'(OW);
         col_in_ff   <= '0;
         pend_ff     <= '0;
         head_ff     <= '0;
         tail_ff     <= '0;
         out_idx_ff  <= '0;
         out_row_ff  <= '0;
         out_col_ff  <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         width_ff    <= width_in;
         height_ff   <= height_in;
         total_m1_ff <= total_m1_in;
         busy_cnt_ff <= busy_cnt_in;
         col_in_ff   <= col_in_in;
         pend_ff     <= pend_in;
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         out_idx_ff  <= out_idx_in;
         out_row_ff  <= out_row_in;
         out_col_ff  <= out_col_in;
         s1_valid_ff <= accept;
      end
   end

   // The older line entry of a column is written in the cycle after its request is taken, so a
   // request on the same column right behind it takes the value from the holding register.
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_pixel_ff    <= !is_drain;
         s1_pop_ff      <= pop;
         s1_interior_ff <= interior && !is_drain;
         s1_last_ff     <= frame_last;
         s1_gray_ff     <= gray;
         s1_col_ff      <= col_in_ff;
         s1_fwd_ff      <= s1_valid_ff && s1_pixel_ff && (s1_col_ff == col_in_ff);
      end
      if (s1_valid_ff && s1_pixel_ff) begin
         newer_hold_ff <= line_new_q;
      end
   end

   lef_ram #(
      .WIDTH (CHAN_WIDTH),
      .DEPTH (MAX_WIDTH)
   ) u_line_old (
      .clock   (clock),
      .wr_en   (s1_valid_ff && s1_pixel_ff),
      .wr_addr (s1_col_ff),
      .wr_data (line_new_q),
      .rd_en   (accept && !is_drain),
      .rd_addr (col_in_ff),
      .rd_data (line_old_q)
   );

   lef_ram #(
      .WIDTH (CHAN_WIDTH),
      .DEPTH (MAX_WIDTH)
   ) u_line_new (
      .clock   (clock),
      .wr_en   (accept && !is_drain),
      .wr_addr (col_in_ff),
      .wr_data (gray),
      .rd_en   (accept && !is_drain),
      .rd_addr (col_in_ff),
      .rd_data (line_new_q)
   );

   lef_ram #(
      .WIDTH (PIX_WIDTH),
      .DEPTH (DD)
   ) u_delay (
      .clock   (clock),
      .wr_en   (accept && !is_drain),
      .wr_addr (tail_ff),
      .wr_data (req_tdata),
      .rd_en   (accept && pop),
      .rd_addr (head_ff),
      .rd_data (delay_q)
   );

   assign older_sel = s1_fwd_ff ? newer_hold_ff : line_old_q;

   assign q_push           = s1_valid_ff;
   assign q_job.pixel      = s1_pixel_ff;
   assign q_job.has_result = s1_pop_ff;
   assign q_job.interior   = s1_interior_ff;
   assign q_job.frame_end  = s1_last_ff;
   assign q_job.colsum     = COLSUM_WIDTH'(older_sel) + COLSUM_WIDTH'(line_new_q) +
                             COLSUM_WIDTH'(s1_gray_ff);
   assign q_job.newer      = line_new_q;
   assign q_job.word       = delay_q;

endmodule

`default_nettype wire

// ===== src/lef_queue.sv =====
// Short job queue between the front end and the back end.
`default_nettype none

module lef_queue import lef_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  lef_job_type             push_job,
   input  logic                    pop,
   output logic                    head_valid,
   output lef_job_type             head_job,
   output logic [QLEVEL_WIDTH-1:0] level
);

   lef_job_type             entries_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QLEVEL_WIDTH-1:0] level_ff;

   assign head_valid = level_ff != '0;
   assign head_job   = entries_ff[rd_ptr_ff];
   assign level      = level_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         level_ff <= level_ff + QLEVEL_WIDTH'(push) - QLEVEL_WIDTH'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

// ===== src/lef_back.sv =====
// Back end: gray window, Laplacian sum, clamp and the result register.
`default_nettype none

module lef_back import lef_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  lef_job_type          q_job,
   output logic                 q_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [PIX_WIDTH-1:0] rsp_tdata,
   output logic                 rsp_tlast
);

   // The window is kept as the sums of its middle and right columns plus the
   // middle gray of the right column, which becomes the centre on the next pixel.
   logic [COLSUM_WIDTH-1:0] csum_m_ff, csum_r_ff;
   logic [CHAN_WIDTH-1:0]   mid_r_ff;
   logic                    rsp_valid_ff;
   logic [PIX_WIDTH-1:0]    rsp_data_ff;
   logic                    rsp_last_ff;

   logic [SUM9_WIDTH-1:0]   mid9, sum9;
   logic [LAP_WIDTH-1:0]    lap;
   logic [SCALED_WIDTH-1:0] scaled;
   logic [CHAN_WIDTH-1:0]   edge_val;
   logic                    out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;
   assign q_pop    = q_valid && (!q_job.has_result || out_free);

   assign mid9   = SUM9_WIDTH'({mid_r_ff, 3'b000}) + SUM9_WIDTH'(mid_r_ff);
   assign sum9   = SUM9_WIDTH'(csum_m_ff) + SUM9_WIDTH'(csum_r_ff) +
                   SUM9_WIDTH'(q_job.colsum);
   assign lap    = {1'b0, mid9} - {1'b0, sum9};
   assign scaled = {lap[LAP_WIDTH-1], lap, 1'b0} + {{2{lap[LAP_WIDTH-1]}}, lap};

   always_comb begin
      if (scaled[SCALED_WIDTH-1]) begin
         edge_val = '0;
      end else if (scaled[SCALED_WIDTH-2:CHAN_WIDTH] != '0) begin
         edge_val = EDGE_MAX;
      end else begin
         edge_val = scaled[CHAN_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csum_m_ff    <= '0;
         csum_r_ff    <= '0;
         mid_r_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop && q_job.pixel) begin
            csum_m_ff <= csum_r_ff;
            csum_r_ff <= q_job.colsum;
            mid_r_ff  <= q_job.newer;
         end
         if (q_pop && q_job.has_result) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_job.has_result) begin
         rsp_last_ff <= q_job.frame_end;
         if (q_job.interior) begin
            rsp_data_ff <= {q_job.word[PIX_WIDTH-1:ALPHA_LSB], edge_val, edge_val, edge_val};
         end else begin
            rsp_data_ff <= q_job.word;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== src/laplacian_edge_filter_core.sv =====
// Top level of the laplacian edge filter: front end, job queue and back end.
//
// Channel  Dir  Handshake               Contents
// req      in   req_tvalid/req_tready   tdata pixel, tuser command (0 pixel, 1 drain)
// rsp      out  rsp_tvalid/rsp_tready   tdata filtered pixel, tlast frame end
// csr      in   csr_valid/csr_ready     csr_index register, csr_data value
//
// One request is taken per cycle while the divider is idle, no register write is offered
// and the job queue has room; a result is offered once the request that releases it has
// passed the line store and delay RAM read, the job queue, then the result register.
// Results lag pixels by frame width plus one pixels; drain requests flush them.
// After reset and after each register write, requests are held off by the bit-serial
// divider that recomputes the output row and column. A stalled rsp side fills the
// four-entry job queue before req_tready drops.
`default_nettype none
`include "laplacian_edge_filter_core_macros.svh"

module laplacian_edge_filter_core import lef_pkg::*; #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   input  logic [PIX_WIDTH-1:0]       req_tdata,   // red, green, blue, alpha
   input  logic [CMD_WIDTH-1:0]       req_tuser,   // command
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [PIX_WIDTH-1:0]       rsp_tdata,   // red, green, blue, alpha
   output logic                       rsp_tlast,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [REG_INDEX_WIDTH-1:0] csr_index,
   input  logic [CFG_WIDTH-1:0]       csr_data
);

   logic                    q_push, q_valid, q_pop;
   lef_job_type             push_job, head_job;
   logic [QLEVEL_WIDTH-1:0] q_level;

   lef_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .q_level    (q_level),
      .q_push     (q_push),
      .q_job      (push_job)
   );

   lef_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (push_job),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_job   (head_job),
      .level      (q_level)
   );

   lef_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_job      (head_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `LEF_ASSERT_NEXT(a_accept_pushes_job, clock, reset, req_tvalid && req_tready, q_push, "accepted request did not reach the job queue")
   `LEF_ASSERT_NOW(a_queue_no_overflow, clock, reset, q_push, q_level < QLEVEL_WIDTH'(QUEUE_DEPTH), "job queue written while full")
   `LEF_ASSERT_NOW(a_pop_only_valid, clock, reset, q_pop, q_valid, "back end took a job from an empty queue")

endmodule

`default_nettype wire
